FILE: hdl/ccl_pkg.sv
// ----------------------------------------------------------------------------
// ccl_pkg
// widths, codes and controller/datapath link types for the chunk cache lookup
// ----------------------------------------------------------------------------
package ccl_pkg;

    localparam int OFFSET_W   = 32;
    localparam int WANTED_W   = 32;
    localparam int CHUNK_W    = 16;
    localparam int POS_W      = 16;
    localparam int COPY_W     = 16;
    localparam int SLOT_W     = 3;
    localparam int STATUS_W   = 2;
    localparam int CL_W       = 16;
    localparam int TOTAL_W    = 32;
    localparam int SLOTS_W    = 4;
    localparam int STAMP_W    = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam int KIND_W     = 2;

    localparam logic [CL_W-1:0]    RST_CHUNK_SIZE   = 16'd58315;
    localparam logic [TOTAL_W-1:0] RST_TOTAL_LENGTH = 32'd0;
    localparam logic [SLOTS_W-1:0] RST_SLOTS_IN_USE = 4'd5;

    localparam logic [STAMP_W-1:0] STAMP_NONE  = 32'hFFFF_FFFF;
    localparam logic [STAMP_W-1:0] STAMP_START = 32'h7FFF_FFFF;
    localparam logic [STAMP_W-1:0] STAMP_FIRST = 32'd1;

    localparam logic OPC_ACCESS = 1'b0;
    localparam logic OPC_CLEAR  = 1'b1;

    localparam logic [STATUS_W-1:0] ST_HIT     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_MISS    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BEYOND  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_CLEARED = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_CHUNK_SIZE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_LENGTH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOTS_IN_USE = 2'd2;

    localparam logic [KIND_W-1:0] RK_LOOKUP = 2'd0;
    localparam logic [KIND_W-1:0] RK_BEYOND = 2'd1;
    localparam logic [KIND_W-1:0] RK_CLEAR  = 2'd2;

    typedef struct packed {
        logic              load;
        logic              div_start;
        logic              size_calc;
        logic              copy_calc;
        logic              scan;
        logic              update;
        logic              clear;
        logic              emit;
        logic [KIND_W-1:0] kind;
    } t_cmd;

    typedef struct packed {
        logic is_clear;
        logic beyond;
        logic div_busy;
        logic chunk_big;
        logic scan_done;
        logic out_free;
    } t_sts;

endpackage

FILE: hdl/ccl_in_if.sv
// ----------------------------------------------------------------------------
// ccl_in_if
// request channel: opcode, byte offset and wanted count
// ----------------------------------------------------------------------------
interface ccl_in_if;
    import ccl_pkg::*;

    logic                valid;
    logic                ready;
    logic                opcode;
    logic [OFFSET_W-1:0] byte_offset;
    logic [WANTED_W-1:0] bytes_wanted;

    modport source (output valid, output opcode, output byte_offset, output bytes_wanted,
                    input ready);
    modport sink   (input valid, input opcode, input byte_offset, input bytes_wanted,
                    output ready);
endinterface

FILE: hdl/ccl_out_if.sv
// ----------------------------------------------------------------------------
// ccl_out_if
// result channel: status, chunk position, copy count and cache slot
// ----------------------------------------------------------------------------
interface ccl_out_if;
    import ccl_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [CHUNK_W-1:0]  chunk_number;
    logic [POS_W-1:0]    offset_in_chunk;
    logic [COPY_W-1:0]   copy_bytes;
    logic [SLOT_W-1:0]   slot;

    modport source (output valid, output status, output chunk_number, output offset_in_chunk,
                    output copy_bytes, output slot, input ready);
    modport sink   (input valid, input status, input chunk_number, input offset_in_chunk,
                    input copy_bytes, input slot, output ready);
endinterface

FILE: hdl/ccl_div.sv
// ----------------------------------------------------------------------------
// ccl_div
// restoring divider, 32-bit dividend by 16-bit divisor, one quotient bit a cycle
// ----------------------------------------------------------------------------
module ccl_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [ccl_pkg::OFFSET_W-1:0] i_dividend,
    input  logic [ccl_pkg::CL_W-1:0]     i_divisor,
    output logic                        o_busy,
    output logic [ccl_pkg::OFFSET_W-1:0] o_quotient,
    output logic [ccl_pkg::CL_W-1:0]     o_remainder
);
    import ccl_pkg::*;

    localparam int STEPS = OFFSET_W;
    localparam int CNT_W = $clog2(STEPS);

    logic             r_busy;
    logic [CNT_W-1:0] r_cnt;
    logic [OFFSET_W-1:0] r_quo;
    logic [CL_W-1:0]     r_rem;
    logic [CL_W-1:0]     r_div;
    logic [CL_W:0]       w_shift;
    logic [CL_W+1:0]     w_diff;
    logic                w_borrow;

    assign w_shift  = {r_rem, r_quo[OFFSET_W-1]};
    assign w_diff   = {1'b0, w_shift} - {2'b00, r_div};
    assign w_borrow = w_diff[CL_W+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == CNT_W'(STEPS - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[OFFSET_W-2:0], ~w_borrow};
            r_rem <= w_borrow ? w_shift[CL_W-1:0] : w_diff[CL_W-1:0];
        end
    end

    assign o_busy      = r_busy;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

endmodule

FILE: hdl/ccl_dp.sv
// ----------------------------------------------------------------------------
// ccl_dp
// datapath: config registers, divider, size math, tag/stamp store, result reg
// ----------------------------------------------------------------------------
module ccl_dp #(
    parameter int CACHE_SLOTS = 8
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [ccl_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [ccl_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_opcode,
    input  logic [ccl_pkg::OFFSET_W-1:0]   i_byte_offset,
    input  logic [ccl_pkg::WANTED_W-1:0]   i_bytes_wanted,
    input  ccl_pkg::t_cmd                  i_cmd,
    output ccl_pkg::t_sts                  o_sts,
    input  logic                           i_out_ready,
    output logic                           o_out_valid,
    output logic [ccl_pkg::STATUS_W-1:0]   o_status,
    output logic [ccl_pkg::CHUNK_W-1:0]    o_chunk_number,
    output logic [ccl_pkg::POS_W-1:0]      o_offset_in_chunk,
    output logic [ccl_pkg::COPY_W-1:0]     o_copy_bytes,
    output logic [ccl_pkg::SLOT_W-1:0]     o_slot
);
    import ccl_pkg::*;

    localparam int SW = (CACHE_SLOTS > 1) ? $clog2(CACHE_SLOTS) : 1;
    localparam int IW = (SW > SLOTS_W) ? SW : SLOTS_W;

    logic [CL_W-1:0]    r_chunk_size;
    logic [TOTAL_W-1:0] r_total_length;
    logic [SLOTS_W-1:0] r_slots_in_use;

    logic                r_opcode;
    logic [OFFSET_W-1:0] r_offset;
    logic [WANTED_W-1:0] r_wanted;
    logic [TOTAL_W-1:0]  r_size;
    logic [CL_W-1:0]     r_room;
    logic [COPY_W-1:0]   r_copy;

    logic [CHUNK_W-1:0] r_tag_mem   [CACHE_SLOTS];
    logic [STAMP_W-1:0] r_stamp_mem [CACHE_SLOTS];
    logic [CACHE_SLOTS-1:0] r_stamp_vld;
    logic [STAMP_W-1:0]     r_stamp_cnt;
    logic [SLOTS_W-1:0]     r_filled;

    logic [IW-1:0]      r_scan_idx;
    logic               r_pend;
    logic [SW-1:0]      r_rd_idx;
    logic [CHUNK_W-1:0] r_rd_tag;
    logic [STAMP_W-1:0] r_rd_stamp;
    logic               r_rd_vld;
    logic               r_hit;
    logic [SW-1:0]      r_hit_idx;
    logic [STAMP_W-1:0] r_min;
    logic [SW-1:0]      r_lru;
    logic [SW-1:0]      r_target;

    logic                r_out_valid;
    logic [STATUS_W-1:0] r_out_status;
    logic [CHUNK_W-1:0]  r_out_chunk;
    logic [POS_W-1:0]    r_out_pos;
    logic [COPY_W-1:0]   r_out_copy;
    logic [SLOT_W-1:0]   r_out_slot;

    logic [CL_W-1:0]     w_cl_eff;
    logic                w_div_busy;
    logic [OFFSET_W-1:0] w_quo;
    logic [CL_W-1:0]     w_rem;
    logic [CHUNK_W-1:0]  w_chunk;
    logic [TOTAL_W-1:0]  w_left;
    logic                w_scan_more;
    logic [SW-1:0]       w_scan_addr;
    logic [STAMP_W-1:0]  w_rd_stamp;
    logic                w_fill_free;
    logic [SW-1:0]       w_target;
    logic [CACHE_SLOTS-1:0] w_tgt_mask;
    logic [STAMP_W-1:0]  w_cnt_inc;
    logic                w_wrap;
    logic [STAMP_W-1:0]  w_stamp_new;
    logic [SLOTS_W-1:0]  w_slots_cfg;
    logic                w_out_free;

    assign w_cl_eff = (r_chunk_size == '0) ? CL_W'(1) : r_chunk_size;

    ccl_div u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_cmd.div_start),
        .i_dividend  (r_offset),
        .i_divisor   (w_cl_eff),
        .o_busy      (w_div_busy),
        .o_quotient  (w_quo),
        .o_remainder (w_rem)
    );

    assign w_chunk     = w_quo[CHUNK_W-1:0];
    assign w_left      = r_total_length - r_offset;
    assign w_scan_more = r_scan_idx < IW'(r_filled);
    assign w_scan_addr = r_scan_idx[SW-1:0];
    assign w_rd_stamp  = r_rd_vld ? r_rd_stamp : STAMP_NONE;
    assign w_fill_free = (r_filled < r_slots_in_use) && (32'(r_filled) < CACHE_SLOTS);
    assign w_target    = r_hit ? r_hit_idx : (w_fill_free ? SW'(r_filled) : r_lru);
    assign w_tgt_mask  = CACHE_SLOTS'(1) << w_target;
    assign w_cnt_inc   = r_stamp_cnt + 1'b1;
    assign w_wrap      = w_cnt_inc[STAMP_W-1];
    assign w_stamp_new = w_wrap ? STAMP_FIRST : w_cnt_inc;
    assign w_slots_cfg = (32'(i_cfg_data[SLOTS_W-1:0]) > CACHE_SLOTS) ? SLOTS_W'(CACHE_SLOTS)
                                                                      : i_cfg_data[SLOTS_W-1:0];
    assign w_out_free  = !r_out_valid || i_out_ready;

    // config and cache bookkeeping
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chunk_size   <= RST_CHUNK_SIZE;
            r_total_length <= RST_TOTAL_LENGTH;
            r_slots_in_use <= RST_SLOTS_IN_USE;
            r_stamp_vld    <= '0;
            r_stamp_cnt    <= '0;
            r_filled       <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_CHUNK_SIZE: begin
                    r_chunk_size <= i_cfg_data[CL_W-1:0];
                end
                CFG_TOTAL_LENGTH: begin
                    r_total_length <= i_cfg_data[TOTAL_W-1:0];
                end
                CFG_SLOTS_IN_USE: begin
                    if (i_cfg_data[SLOTS_W-1:0] != '0) begin
                        r_slots_in_use <= w_slots_cfg;
                        r_stamp_vld    <= '0;
                        r_stamp_cnt    <= '0;
                        r_filled       <= '0;
                    end
                end
                default: begin
                end
            endcase
        end else if (i_cmd.clear) begin
            r_filled <= '0;
        end else if (i_cmd.update) begin
            r_stamp_cnt <= w_stamp_new;
            r_stamp_vld <= w_wrap ? w_tgt_mask : (r_stamp_vld | w_tgt_mask);
            if (!r_hit && w_fill_free) begin
                r_filled <= r_filled + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_opcode <= i_opcode;
            r_offset <= i_byte_offset;
            r_wanted <= i_bytes_wanted;
        end
        if (i_cmd.size_calc) begin
            r_size <= (r_wanted < w_left) ? r_wanted : w_left;
            r_room <= w_cl_eff - w_rem;
        end
        if (i_cmd.copy_calc) begin
            r_copy <= (TOTAL_W'(r_room) < r_size) ? r_room : r_size[COPY_W-1:0];
        end
    end

    // tag and stamp store
    always_ff @(posedge i_clk) begin
        if (i_cmd.update) begin
            if (!r_hit) begin
                r_tag_mem[w_target] <= w_chunk;
            end
            r_stamp_mem[w_target] <= w_stamp_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan && w_scan_more) begin
            r_rd_tag   <= r_tag_mem[w_scan_addr];
            r_rd_stamp <= r_stamp_mem[w_scan_addr];
            r_rd_vld   <= r_stamp_vld[w_scan_addr];
            r_rd_idx   <= w_scan_addr;
        end
    end

    // slot scan: first tag match and oldest stamp
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_idx <= '0;
            r_pend     <= 1'b0;
        end else if (i_cmd.copy_calc) begin
            r_scan_idx <= '0;
            r_pend     <= 1'b0;
        end else begin
            r_pend <= i_cmd.scan && w_scan_more;
            if (i_cmd.scan && w_scan_more) begin
                r_scan_idx <= r_scan_idx + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.copy_calc) begin
            r_hit     <= 1'b0;
            r_hit_idx <= '0;
            r_min     <= STAMP_START;
            r_lru     <= '0;
        end else if (r_pend) begin
            if (!r_hit && r_rd_tag == w_chunk) begin
                r_hit     <= 1'b1;
                r_hit_idx <= r_rd_idx;
            end
            if ($signed(w_rd_stamp) < $signed(r_min)) begin
                r_min <= w_rd_stamp;
                r_lru <= r_rd_idx;
            end
        end
        if (i_cmd.update) begin
            r_target <= w_target;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            unique case (i_cmd.kind)
                RK_LOOKUP: begin
                    r_out_status <= r_hit ? ST_HIT : ST_MISS;
                    r_out_chunk  <= w_chunk;
                    r_out_pos    <= w_rem;
                    r_out_copy   <= r_copy;
                    r_out_slot   <= SLOT_W'(r_target);
                end
                RK_CLEAR: begin
                    r_out_status <= ST_CLEARED;
                    r_out_chunk  <= '0;
                    r_out_pos    <= '0;
                    r_out_copy   <= '0;
                    r_out_slot   <= '0;
                end
                default: begin
                    r_out_status <= ST_BEYOND;
                    r_out_chunk  <= '0;
                    r_out_pos    <= '0;
                    r_out_copy   <= '0;
                    r_out_slot   <= '0;
                end
            endcase
        end
    end

    assign o_sts.is_clear  = (r_opcode == OPC_CLEAR);
    assign o_sts.beyond    = (r_offset >= r_total_length);
    assign o_sts.div_busy  = w_div_busy;
    assign o_sts.chunk_big = |w_quo[OFFSET_W-1:CHUNK_W];
    assign o_sts.scan_done = !w_scan_more && !r_pend;
    assign o_sts.out_free  = w_out_free;

    assign o_out_valid       = r_out_valid;
    assign o_status          = r_out_status;
    assign o_chunk_number    = r_out_chunk;
    assign o_offset_in_chunk = r_out_pos;
    assign o_copy_bytes      = r_out_copy;
    assign o_slot            = r_out_slot;

endmodule

FILE: hdl/ccl_ctrl.sv
// ----------------------------------------------------------------------------
// ccl_ctrl
// sequencer: range check, divide, size, slot scan, update, result hand-off
// ----------------------------------------------------------------------------
module ccl_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  ccl_pkg::t_sts i_sts,
    output ccl_pkg::t_cmd o_cmd
);
    import ccl_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_RANGE  = 3'd1;
    localparam logic [2:0] S_DIV    = 3'd2;
    localparam logic [2:0] S_SIZE   = 3'd3;
    localparam logic [2:0] S_COPY   = 3'd4;
    localparam logic [2:0] S_SCAN   = 3'd5;
    localparam logic [2:0] S_UPDATE = 3'd6;
    localparam logic [2:0] S_FINISH = 3'd7;

    logic [2:0]        r_state;
    logic [2:0]        n_state;
    logic [KIND_W-1:0] r_kind;
    logic [KIND_W-1:0] n_kind;

    always_comb begin
        n_state = r_state;
        n_kind  = r_kind;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.load = i_in_valid;
                if (i_in_valid) begin
                    n_state = S_RANGE;
                end
            end
            S_RANGE: begin
                priority if (i_sts.is_clear) begin
                    o_cmd.clear = 1'b1;
                    n_kind      = RK_CLEAR;
                    n_state     = S_FINISH;
                end else if (i_sts.beyond) begin
                    n_kind  = RK_BEYOND;
                    n_state = S_FINISH;
                end else begin
                    o_cmd.div_start = 1'b1;
                    n_kind          = RK_LOOKUP;
                    n_state         = S_DIV;
                end
            end
            S_DIV: begin
                if (!i_sts.div_busy) begin
                    n_state = S_SIZE;
                end
            end
            S_SIZE: begin
                o_cmd.size_calc = 1'b1;
                if (i_sts.chunk_big) begin
                    n_kind  = RK_BEYOND;
                    n_state = S_FINISH;
                end else begin
                    n_state = S_COPY;
                end
            end
            S_COPY: begin
                o_cmd.copy_calc = 1'b1;
                n_state         = S_SCAN;
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_sts.scan_done) begin
                    n_state = S_UPDATE;
                end
            end
            S_UPDATE: begin
                o_cmd.update = 1'b1;
                n_state      = S_FINISH;
            end
            S_FINISH: begin
                o_cmd.kind = r_kind;
                o_cmd.emit = i_sts.out_free;
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_kind  <= RK_LOOKUP;
        end else begin
            r_state <= n_state;
            r_kind  <= n_kind;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

endmodule

FILE: hdl/chunk_cache_lru_lookup.sv
// ----------------------------------------------------------------------------
// chunk_cache_lru_lookup
// chunk lookup for a byte offset with a timestamp lru tag cache
// ----------------------------------------------------------------------------
// i_in carries one request beat: opcode, byte_offset, bytes_wanted.
// o_out carries one result beat per request: status, chunk_number,
// offset_in_chunk, copy_bytes, slot. both are valid/ready channels.
// registers chunk_size, total_length and slots_in_use are written through
// i_cfg_we / i_cfg_idx / i_cfg_data; the user must write them only while no
// request is in flight, the block itself does not enforce it.
// a lookup runs the range check, the one-bit-per-cycle divider, size math,
// a scan of the filled slots of the tag/stamp store, update and hand-off.
// a clear request or an offset at or past the end goes from the range check
// straight to the hand-off; a chunk number too large for 16 bits ends a lookup
// after the size math, also with status beyond.
// one request is worked on at a time; the next beat is taken as soon as
// the result sits in the output register, even while it is still waiting.
// if the receiver stalls with a result already held, the next result waits
// in the sequencer until the register frees up.
// reset loads the register defaults and empties the cache at once.
// ----------------------------------------------------------------------------
module chunk_cache_lru_lookup #(
    parameter int CACHE_SLOTS = 8
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [ccl_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [ccl_pkg::CFG_DATA_W-1:0] i_cfg_data,
    ccl_in_if.sink                         i_in,
    ccl_out_if.source                      o_out
);
    import ccl_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;
    logic w_in_ready;

    ccl_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (w_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    ccl_dp #(
        .CACHE_SLOTS (CACHE_SLOTS)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_data        (i_cfg_data),
        .i_opcode          (i_in.opcode),
        .i_byte_offset     (i_in.byte_offset),
        .i_bytes_wanted    (i_in.bytes_wanted),
        .i_cmd             (w_cmd),
        .o_sts             (w_sts),
        .i_out_ready       (o_out.ready),
        .o_out_valid       (o_out.valid),
        .o_status          (o_out.status),
        .o_chunk_number    (o_out.chunk_number),
        .o_offset_in_chunk (o_out.offset_in_chunk),
        .o_copy_bytes      (o_out.copy_bytes),
        .o_slot            (o_out.slot)
    );

    assign i_in.ready = w_in_ready;

`ifndef SYNTHESIS
    a_no_ready_after_accept: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !i_in.ready
    ) else $error("request taken while previous one still in work");

    a_empty_fields: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && (o_out.status == ST_BEYOND || o_out.status == ST_CLEARED))
        |-> (o_out.chunk_number == '0 && o_out.offset_in_chunk == '0 &&
             o_out.copy_bytes == '0 && o_out.slot == '0)
    ) else $error("non-lookup result carries nonzero fields");

    a_slot_range: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && (o_out.status == ST_HIT || o_out.status == ST_MISS))
        |-> ((CACHE_SLOTS >= 8) || (32'(o_out.slot) < CACHE_SLOTS))
    ) else $error("slot out of range");

    a_emit_needs_room: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.ready) |=> o_out.valid
    ) else $error("held result dropped");
`endif

endmodule

FILE: bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the chunk cache lookup with timestamp lru
// ----------------------------------------------------------------------------
// a short table of directed steps runs first: register extremes, out-of-range
// offsets, too many chunks, zero chunk length, zero wanted bytes, ignored and
// clamped slot counts, a full cache with eviction, and clears. phases of random
// beats follow, each under new register settings, mostly offsets inside a
// working set of chunks a little larger than the cache so that hits, fills and
// evictions all happen. every accepted request beat runs through a local
// model of the tag cache and each result beat is compared field by field.
// the sender works in bursts with random gaps, the receiver stalls on
// a changing pattern.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import ccl_pkg::*;

    localparam int N_SLOTS         = 8;
    localparam int N_PHASES        = 10;
    localparam int BEATS_PER_PHASE = 63;
    localparam int DRAIN_CYCLES    = 60;
    localparam int CYCLE_LIMIT     = 500000;

    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 2'd3;

    typedef enum logic {ROW_BEAT, ROW_REG} t_row_kind;

    typedef struct packed {
        t_row_kind             kind;
        logic [CFG_IDX_W-1:0]  reg_idx;
        logic [CFG_DATA_W-1:0] reg_data;
        logic                  opcode;
        logic [OFFSET_W-1:0]   byte_offset;
        logic [WANTED_W-1:0]   bytes_wanted;
        logic                  fixed;
        logic [STATUS_W-1:0]   fixed_status;
    } t_step;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [CHUNK_W-1:0]  chunk_number;
        logic [POS_W-1:0]    offset_in_chunk;
        logic [COPY_W-1:0]   copy_bytes;
        logic [SLOT_W-1:0]   slot;
    } t_lookup;

    localparam int N_DIRECTED = 31;
    localparam t_step DIRECTED_STEPS [N_DIRECTED] = '{
        '{ROW_BEAT, CFG_UNMAPPED,     32'h0, OPC_ACCESS, 32'h0000_0000, 32'h0000_0001, 1'b1, ST_BEYOND},
        '{ROW_BEAT, CFG_UNMAPPED,     32'h0, OPC_CLEAR,  32'h0000_0000, 32'h0000_0000, 1'b1, ST_CLEARED},
        '{ROW_REG,  CFG_TOTAL_LENGTH, 32'hFFFF_FFFF, OPC_ACCESS, 32'h0, 32'h0, 1'b0, ST_HIT},
        '{ROW_REG,  CFG_CHUNK_SIZE,   32'h0000_FFFF, OPC_ACCESS, 32'h0, 32'h0, 1'b0, ST_HIT},
        '{ROW_BEAT, CFG_UNMAPPED,     32'h0, OPC_ACCESS, 32'hFFFF_FFFE, 32'h0000_0001, 1'b1, ST_BEYOND},
        '{ROW_BEAT, CFG_UNMAPPED,     32'h0, OPC_ACCESS, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, ST_BEYOND},
        '{ROW_BEAT, CFG_UNMAPPED,     32'h0, OPC_ACCESS, 32'hFFFE_FFFF, 32'hFFFF_FFFF, 1'b0, ST_HIT},
        '{ROW_BEAT, CFG_UNMAPPED,     32'h0, OPC_ACCESS, 32'h0000_0000, 32'h0000_0000, 1'b0, ST_HIT},
        '{ROW_BEAT, CFG_UNMAPPED,     32'h0, OPC_ACCESS, 32'h0000_0000, 32'hFFFF_FFFF, 1'b0, ST_HIT},
        '{ROW_REG,  CFG_UNMAPPED,     32'hFFFF_FFFF, OPC_ACCESS, 32'h0, 32'h0, 1'b0, ST_HIT},
        '{ROW_REG,  CFG_CHUNK_SIZE,   32'h0000_0000, OPC_ACCESS, 32'h0, 32'h0, 1'b0, ST_HIT},
        '{ROW_BEAT, CFG_UNMAPPED,     32'h0, OPC_ACCESS, 32'h0000_FFFF, 32'h0000_0005, 1'b0, ST_HIT},
        '{ROW_BEAT, CFG_UNMAPPED,     32'h0, OPC_ACCESS, 32'h0001_0000, 32'h0000_0001, 1'b1, ST_BEYOND},
        '{ROW_REG,  CFG_SLOTS_IN_USE, 32'h0000_0000, OPC_ACCESS, 32'h0, 32'h0, 1'b0, ST_HIT},
        '{ROW_BEAT, CFG_UNMAPPED,     32'h0, OPC_ACCESS, 32'h0000_0003, 32'h0000_0002, 1'b0, ST_HIT},
        '{ROW_REG,  CFG_SLOTS_IN_USE, 32'h0000_0001, OPC_ACCESS, 32'h0, 32'h0, 1'b0, ST_HIT},
        '{ROW_BEAT, CFG_UNMAPPED,     32'h0, OPC_ACCESS, 32'h0000_0007, 32'h0000_0001, 1'b0, ST_HIT},
        '{ROW_BEAT, CFG_UNMAPPED,     32'h0, OPC_ACCESS, 32'h0000_0008, 32'h0000_0001, 1'b0, ST_HIT},
        '{ROW_BEAT, CFG_UNMAPPED,     32'h0, OPC_ACCESS, 32'h0000_0008, 32'h0000_0001, 1'b0, ST_HIT},
        '{ROW_REG,  CFG_SLOTS_IN_USE, 32'h0000_000F, OPC_ACCESS, 32'h0, 32'h0, 1'b0, ST_HIT},
        '{ROW_BEAT, CFG_UNMAPPED,     32'h0, OPC_ACCESS, 32'h0000_0000, 32'h0000_0001, 1'b0, ST_HIT},
        '{ROW_BEAT, CFG_UNMAPPED,     32'h0, OPC_ACCESS, 32'h0000_0001, 32'h0000_0001, 1'b0, ST_HIT},
        '{ROW_BEAT, CFG_UNMAPPED,     32'h0, OPC_ACCESS, 32'h0000_0002, 32'h0000_0001, 1'b0, ST_HIT},
        '{ROW_BEAT, CFG_UNMAPPED,     32'h0, OPC_ACCESS, 32'h0000_0003, 32'h0000_0001, 1'b0, ST_HIT},
        '{ROW_BEAT, CFG_UNMAPPED,     32'h0, OPC_ACCESS, 32'h0000_0004, 32'h0000_0001, 1'b0, ST_HIT},
        '{ROW_BEAT, CFG_UNMAPPED,     32'h0, OPC_ACCESS, 32'h0000_0005, 32'h0000_0001, 1'b0, ST_HIT},
        '{ROW_BEAT, CFG_UNMAPPED,     32'h0, OPC_ACCESS, 32'h0000_0006, 32'h0000_0001, 1'b0, ST_HIT},
        '{ROW_BEAT, CFG_UNMAPPED,     32'h0, OPC_ACCESS, 32'h0000_0007, 32'h0000_0001, 1'b0, ST_HIT},
        '{ROW_BEAT, CFG_UNMAPPED,     32'h0, OPC_ACCESS, 32'h0000_0008, 32'h0000_0001, 1'b0, ST_HIT},
        '{ROW_BEAT, CFG_UNMAPPED,     32'h0, OPC_CLEAR,  32'h0000_0000, 32'h0000_0000, 1'b1, ST_CLEARED},
        '{ROW_BEAT, CFG_UNMAPPED,     32'h0, OPC_ACCESS, 32'h0000_0001, 32'h0000_0001, 1'b0, ST_HIT}
    };

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    ccl_in_if  req_if ();
    ccl_out_if rsp_if ();

    chunk_cache_lru_lookup #(
        .CACHE_SLOTS(N_SLOTS)
    ) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (req_if),
        .o_out      (rsp_if)
    );

    // local copy of the registers and the tag cache
    logic [CL_W-1:0]    chunk_len;
    logic [TOTAL_W-1:0] file_len;
    int                 slots_active;
    logic [CHUNK_W-1:0] slot_tag   [N_SLOTS];
    logic [STAMP_W-1:0] slot_stamp [N_SLOTS];
    logic [STAMP_W-1:0] stamp_ctr;
    int                 slots_filled;

    t_lookup     pending_lookups [$];
    int unsigned err_count;
    int unsigned cycle_count;
    int          burst_left;
    logic        beat_fixed;
    logic [STATUS_W-1:0] beat_fixed_status;
    logic [15:0] ready_pattern;
    int          ready_age;

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    function automatic void empty_cache();
        for (int i = 0; i < N_SLOTS; i++) slot_stamp[i] = STAMP_NONE;
        stamp_ctr    = '0;
        slots_filled = 0;
    endfunction

    function automatic void apply_register(logic [CFG_IDX_W-1:0] idx,
                                           logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_CHUNK_SIZE:   chunk_len = data[CL_W-1:0];
            CFG_TOTAL_LENGTH: file_len  = data[TOTAL_W-1:0];
            CFG_SLOTS_IN_USE: begin
                if (data[SLOTS_W-1:0] != '0) begin
                    slots_active = (data[SLOTS_W-1:0] > N_SLOTS) ? N_SLOTS
                                                                 : int'(data[SLOTS_W-1:0]);
                    empty_cache();
                end
            end
            default: ;
        endcase
    endfunction

    function automatic t_lookup lookup_chunk(logic opcode, logic [OFFSET_W-1:0] offset,
                                             logic [WANTED_W-1:0] wanted);
        t_lookup            res;
        logic [31:0]        cl;
        logic [31:0]        chunk;
        logic [31:0]        pos;
        logic [31:0]        size;
        logic [31:0]        room;
        logic [31:0]        copy;
        logic signed [31:0] oldest;
        logic               hit;
        int                 tgt;
        int                 lru;
        res = '0;
        if (opcode == OPC_CLEAR) begin
            slots_filled = 0;
            res.status = ST_CLEARED;
            return res;
        end
        if (offset >= file_len) begin
            res.status = ST_BEYOND;
            return res;
        end
        cl    = (chunk_len == '0) ? 32'd1 : {16'd0, chunk_len};
        chunk = offset / cl;
        pos   = offset % cl;
        if (chunk > 32'h0000_FFFF) begin
            res.status = ST_BEYOND;
            return res;
        end
        size = file_len - offset;
        if (wanted < size) size = wanted;
        room = cl - pos;
        copy = (room < size) ? room : size;

        hit = 1'b0;
        tgt = 0;
        for (int i = 0; i < slots_filled; i++) begin
            if (!hit && slot_tag[i] == chunk[CHUNK_W-1:0]) begin
                hit = 1'b1;
                tgt = i;
            end
        end
        if (!hit) begin
            lru    = 0;
            oldest = STAMP_START;
            for (int i = 0; i < slots_filled; i++) begin
                if ($signed(slot_stamp[i]) < oldest) begin
                    oldest = slot_stamp[i];
                    lru    = i;
                end
            end
            if (slots_filled < slots_active) begin
                tgt = slots_filled;
                slots_filled++;
            end else begin
                tgt = lru;
            end
            slot_tag[tgt] = chunk[CHUNK_W-1:0];
        end
        stamp_ctr       = stamp_ctr + 1;
        slot_stamp[tgt] = stamp_ctr;
        if (stamp_ctr[STAMP_W-1]) begin
            // stamp wrap: forget the age of every filled slot
            for (int i = 0; i < slots_filled; i++) slot_stamp[i] = STAMP_NONE;
            stamp_ctr       = STAMP_FIRST;
            slot_stamp[tgt] = STAMP_FIRST;
        end

        res.status          = hit ? ST_HIT : ST_MISS;
        res.chunk_number    = chunk[CHUNK_W-1:0];
        res.offset_in_chunk = pos[POS_W-1:0];
        res.copy_bytes      = copy[COPY_W-1:0];
        res.slot            = tgt[SLOT_W-1:0];
        return res;
    endfunction

    function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (act_v !== exp_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            err_count++;
        end
    endfunction

    // result check first, then the prediction for a request beat taken this edge
    always @(posedge i_clk) begin
        t_lookup exp_r;
        t_lookup pred;
        if (i_rst_n) begin
            if (rsp_if.valid && rsp_if.ready) begin
                if (pending_lookups.size() == 0) begin
                    $error("result beat with no lookup pending");
                    err_count++;
                end else begin
                    exp_r = pending_lookups.pop_front();
                    check_field("status", 32'(exp_r.status), 32'(rsp_if.status));
                    check_field("chunk_number", 32'(exp_r.chunk_number),
                                32'(rsp_if.chunk_number));
                    check_field("offset_in_chunk", 32'(exp_r.offset_in_chunk),
                                32'(rsp_if.offset_in_chunk));
                    check_field("copy_bytes", 32'(exp_r.copy_bytes), 32'(rsp_if.copy_bytes));
                    check_field("slot", 32'(exp_r.slot), 32'(rsp_if.slot));
                end
            end
            if (req_if.valid && req_if.ready) begin
                pred = lookup_chunk(req_if.opcode, req_if.byte_offset, req_if.bytes_wanted);
                if (beat_fixed) begin
                    pred        = '0;
                    pred.status = beat_fixed_status;
                end
                pending_lookups.push_back(pred);
            end
        end
    end

    // receiver stalls on a random ready pattern, redrawn when its age counter runs out
    always @(negedge i_clk) begin
        if (ready_age == 0) begin
            ready_pattern = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom) | 16'h0001;
            ready_age     = 64;
        end
        ready_age--;
        rsp_if.ready <= ready_pattern[ready_age % 16];
    end

    always @(posedge i_clk) cycle_count <= cycle_count + 1;

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("status: fail");
        $finish;
    end

    task automatic send_beat(logic opcode, logic [OFFSET_W-1:0] offset,
                             logic [WANTED_W-1:0] wanted, logic fixed,
                             logic [STATUS_W-1:0] fixed_status);
        int gap;
        @(negedge i_clk);
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                req_if.valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        req_if.valid        <= 1'b1;
        req_if.opcode       <= opcode;
        req_if.byte_offset  <= offset;
        req_if.bytes_wanted <= wanted;
        beat_fixed          <= fixed;
        beat_fixed_status   <= fixed_status;
        do @(posedge i_clk); while (!req_if.ready);
        burst_left--;
    endtask

    task automatic drain();
        @(negedge i_clk);
        req_if.valid <= 1'b0;
        while (pending_lookups.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        apply_register(idx, data);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        int unsigned eff_cl;
        int unsigned cl_sel;
        longint      total;
        longint      n_chunks;
        longint      offset;
        longint      work_set;
        int unsigned wanted;
        int unsigned pick;
        logic        opcode;

        i_rst_n             = 1'b0;
        i_cfg_we            = 1'b0;
        i_cfg_idx           = '0;
        i_cfg_data          = '0;
        req_if.valid        = 1'b0;
        req_if.opcode       = OPC_ACCESS;
        req_if.byte_offset  = '0;
        req_if.bytes_wanted = '0;
        rsp_if.ready        = 1'b0;
        beat_fixed          = 1'b0;
        beat_fixed_status   = ST_HIT;
        err_count           = 0;
        cycle_count         = 0;
        burst_left          = 0;
        ready_age           = 0;

        chunk_len    = RST_CHUNK_SIZE;
        file_len     = RST_TOTAL_LENGTH;
        slots_active = int'(RST_SLOTS_IN_USE);
        for (int i = 0; i < N_SLOTS; i++) slot_tag[i] = '0;
        empty_cache();

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (DIRECTED_STEPS[k]) begin
            if (DIRECTED_STEPS[k].kind == ROW_REG) begin
                drain();
                write_reg(DIRECTED_STEPS[k].reg_idx, DIRECTED_STEPS[k].reg_data);
            end else begin
                send_beat(DIRECTED_STEPS[k].opcode, DIRECTED_STEPS[k].byte_offset,
                          DIRECTED_STEPS[k].bytes_wanted, DIRECTED_STEPS[k].fixed,
                          DIRECTED_STEPS[k].fixed_status);
            end
        end

        for (int ph = 0; ph < N_PHASES; ph++) begin
            case (ph)
                0:       cl_sel = 1;
                1:       cl_sel = 16'hFFFF;
                2:       cl_sel = 0;
                default: cl_sel = $urandom_range(0, 1) ? $urandom_range(1, 64)
                                                       : $urandom_range(1, 65535);
            endcase
            eff_cl = (cl_sel == 0) ? 1 : cl_sel;
            case (ph)
                1, 3:    total = 64'h0000_0000_FFFF_FFFF;
                4:       total = $urandom_range(1, eff_cl);
                default: total = longint'(eff_cl) * $urandom_range(1, 12)
                                 + $urandom_range(0, eff_cl - 1);
            endcase
            if (total > 64'h0000_0000_FFFF_FFFF) total = 64'h0000_0000_FFFF_FFFF;

            drain();
            write_reg(CFG_CHUNK_SIZE, CFG_DATA_W'(cl_sel));
            write_reg(CFG_TOTAL_LENGTH, CFG_DATA_W'(total));
            case (ph)
                0:       write_reg(CFG_SLOTS_IN_USE, 32'd1);
                1:       write_reg(CFG_SLOTS_IN_USE, 32'd8);
                2:       write_reg(CFG_SLOTS_IN_USE, 32'd15);
                default: if ($urandom_range(0, 2) != 0)
                             write_reg(CFG_SLOTS_IN_USE, $urandom_range(0, 15));
            endcase

            n_chunks = (total + eff_cl - 1) / eff_cl;
            if (n_chunks > 65536) n_chunks = 65536;
            work_set = slots_active + $urandom_range(0, 3);
            if (work_set > n_chunks) work_set = n_chunks;

            for (int n = 0; n < BEATS_PER_PHASE; n++) begin
                pick   = $urandom_range(0, 99);
                opcode = OPC_ACCESS;
                if (pick < 5) begin
                    opcode = OPC_CLEAR;
                    offset = $urandom;
                end else if (pick < 80) begin
                    offset = longint'($urandom_range(0, work_set - 1)) * eff_cl
                             + $urandom_range(0, eff_cl - 1);
                    if (offset >= total) offset = total - 1;
                end else if (pick < 90) begin
                    offset = total + $urandom_range(0, 1000);
                    if (offset > 64'h0000_0000_FFFF_FFFF) offset = 64'h0000_0000_FFFF_FFFF;
                end else begin
                    offset = $urandom;
                end
                case ($urandom_range(0, 3))
                    0:       wanted = $urandom_range(0, eff_cl * 2);
                    1:       wanted = $urandom;
                    2:       wanted = 32'hFFFF_FFFF;
                    default: wanted = $urandom_range(0, 3);
                endcase
                send_beat(opcode, OFFSET_W'(offset), wanted, 1'b0, ST_HIT);
            end
        end

        drain();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (err_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
